// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VCOM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VCOM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vcom_pkg.sv =====
// ----------------------------------------------------------------------------
// vcom_pkg
// sizes, register map and line buffer entry type of the curvature mask
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vcom_pkg;

	localparam int MAX_COLUMNS  = 2048;
	localparam int MAX_ROWS     = 128;
	localparam int HEIGHT_WIDTH = 20;

	localparam int ROWS_CFG_W = 8;
	localparam int COLS_CFG_W = 12;
	localparam int THR_W      = 20;

	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(16);
	localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(1800);
	localparam logic [THR_W-1:0]      THR_RESET  = THR_W'(82);

	localparam int MIN_ROWS = 3;

	localparam int COL_W    = $clog2(MAX_COLUMNS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COLS_N_W = COL_W + 1;
	localparam int ROWS_N_W = ROW_W + 1;
	localparam int CCMP_W   = (COLS_CFG_W > COLS_N_W) ? COLS_CFG_W : COLS_N_W;
	localparam int RCMP_W   = (ROWS_CFG_W > ROWS_N_W) ? ROWS_CFG_W : ROWS_N_W;
	localparam int SUM_W    = HEIGHT_WIDTH + 3;
	localparam int CMP_W    = (SUM_W > THR_W + 1) ? SUM_W : THR_W + 1;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [1:0] REG_COL_COUNT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	typedef logic signed [HEIGHT_WIDTH-1:0] height_t;

	typedef struct packed {
		height_t older_z;
		logic    older_v;
		height_t newer_z;
		logic    newer_v;
	} line_entry_t;

	localparam int ENTRY_W = $bits(line_entry_t);

endpackage

`default_nettype wire

// ===== rtl/vcom_if.sv =====
// ----------------------------------------------------------------------------
// vcom_if
// valid/ready channels for pixels in and mask results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vcom_pixel_if;
	logic              valid;
	logic              ready;
	vcom_pkg::height_t height_z;
	logic              point_valid;

	modport source (output valid, output height_z, output point_valid, input ready);
	modport sink (input valid, input height_z, input point_valid, output ready);
endinterface

interface vcom_mark_if;
	logic valid;
	logic ready;
	logic obstacle_mark;
	logic row_last;
	logic frame_last;

	modport source (output valid, output obstacle_mark, output row_last, output frame_last,
		input ready);
	modport sink (input valid, input obstacle_mark, input row_last, input frame_last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/vcom_ram.sv =====
// ----------------------------------------------------------------------------
// vcom_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vcom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vertical_curvature_obstacle_mask_core.sv =====
// ----------------------------------------------------------------------------
// vertical_curvature_obstacle_mask_core
// marks pixels of a range image whose vertical height curvature is too large
// ----------------------------------------------------------------------------
// pixels enter on the pixel channel in raster order, one item per clock when
// the result side keeps up. for pixel (r,c) with r >= 1 one item leaves on the
// mark channel for pixel (r-1,c); row 0 pixels give no item. an item with
// row_last high ends a row, frame_last high ends a frame.
// from pixel accept to result valid, the accept registers the line buffer read
// into stage 1; when stage 1 advances, the difference, compare and result are
// registered in the result register.
// throughput is one item per cycle; the single line buffer ram takes one read
// and one write each cycle, with a bypass when both hit the same column.
// if the receiver stalls, the result register holds, the pixel in stage 1
// waits and pixel ready drops in the same cycle; no item is lost.
// reset clears row and column counters, both stage valid flags and the registers
// (rows 16, columns 1800, threshold 82). line buffer contents are not cleared:
// the first two rows of a frame fill them before any mark depends on them.
// the apb registers must be written with the block idle (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vertical_curvature_obstacle_mask_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	vcom_pixel_if.sink                           pixel,
	vcom_mark_if.source                          mark,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [vcom_pkg::APB_AW-1:0]     paddr,
	input  wire logic [vcom_pkg::APB_DW-1:0]     pwdata,
	output logic      [vcom_pkg::APB_DW-1:0]     prdata,
	output logic                                 pready
);

	logic [vcom_pkg::ROWS_CFG_W-1:0] row_count_q;
	logic [vcom_pkg::COLS_CFG_W-1:0] column_count_q;
	logic [vcom_pkg::THR_W-1:0]      threshold_q;

	logic [vcom_pkg::COL_W-1:0] col_q;
	logic [vcom_pkg::ROW_W-1:0] row_q;

	logic                       valid_s1;
	vcom_pkg::height_t          z_s1;
	logic                       v_s1;
	logic [vcom_pkg::COL_W-1:0] addr_s1;
	logic                       emit_s1;
	logic                       band_s1;
	logic                       rlast_s1;
	logic                       flast_s1;
	logic                       fwd_s1;
	vcom_pkg::line_entry_t      fwd_data_s1;

	logic out_valid_q;
	logic mark_q;
	logic rlast_q;
	logic flast_q;

	logic                            accept;
	logic                            s1_adv;
	logic                            cfg_wr;
	logic [vcom_pkg::CCMP_W-1:0]     cols_x;
	logic [vcom_pkg::RCMP_W-1:0]     rows_x;
	logic [vcom_pkg::COLS_N_W-1:0]   cols_eff;
	logic [vcom_pkg::ROWS_N_W-1:0]   rows_eff;
	logic [vcom_pkg::ROWS_N_W:0]     quarter;
	logic [vcom_pkg::ROWS_N_W:0]     band_top;
	logic                            end_of_row;
	logic                            end_of_frame;
	logic                            in_band;
	logic [vcom_pkg::ENTRY_W-1:0]    rd_raw;
	vcom_pkg::line_entry_t           rd_entry;
	vcom_pkg::line_entry_t           cur_entry;
	vcom_pkg::line_entry_t           wr_entry;
	logic signed [vcom_pkg::CMP_W-1:0] sum;
	logic signed [vcom_pkg::CMP_W-1:0] thr_x;
	logic                            mark_d;

	// apb registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= vcom_pkg::ROWS_RESET;
			column_count_q <= vcom_pkg::COLS_RESET;
			threshold_q    <= vcom_pkg::THR_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				vcom_pkg::REG_ROW_COUNT: row_count_q <= pwdata[vcom_pkg::ROWS_CFG_W-1:0];
				vcom_pkg::REG_COL_COUNT: column_count_q <= pwdata[vcom_pkg::COLS_CFG_W-1:0];
				vcom_pkg::REG_THRESHOLD: threshold_q <= pwdata[vcom_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			vcom_pkg::REG_ROW_COUNT: prdata = vcom_pkg::APB_DW'(row_count_q);
			vcom_pkg::REG_COL_COUNT: prdata = vcom_pkg::APB_DW'(column_count_q);
			vcom_pkg::REG_THRESHOLD: prdata = vcom_pkg::APB_DW'(threshold_q);
			default:                 prdata = '0;
		endcase
	end

	// effective frame size
	always_comb begin
		cols_x = vcom_pkg::CCMP_W'(column_count_q);
		if (cols_x == '0) begin
			cols_x = vcom_pkg::CCMP_W'(1);
		end else if (cols_x > vcom_pkg::CCMP_W'(vcom_pkg::MAX_COLUMNS)) begin
			cols_x = vcom_pkg::CCMP_W'(vcom_pkg::MAX_COLUMNS);
		end
		cols_eff = vcom_pkg::COLS_N_W'(cols_x);

		rows_x = vcom_pkg::RCMP_W'(row_count_q);
		if (rows_x < vcom_pkg::RCMP_W'(vcom_pkg::MIN_ROWS)) begin
			rows_x = vcom_pkg::RCMP_W'(vcom_pkg::MIN_ROWS);
		end else if (rows_x > vcom_pkg::RCMP_W'(vcom_pkg::MAX_ROWS)) begin
			rows_x = vcom_pkg::RCMP_W'(vcom_pkg::MAX_ROWS);
		end
		rows_eff = vcom_pkg::ROWS_N_W'(rows_x);
	end

	// position of the incoming pixel
	assign end_of_row   = ({1'b0, col_q} + 1'b1) >= cols_eff;
	assign end_of_frame = end_of_row && (({1'b0, row_q} + 1'b1) >= rows_eff);
	assign quarter      = {1'b0, rows_eff} >> 2;
	assign band_top     = quarter + (quarter << 1);
	// result row e = row - 1 must satisfy 1 <= e and e + 2 <= top
	assign in_band      = (row_q >= vcom_pkg::ROW_W'(2))
		&& ((vcom_pkg::ROWS_N_W + 1)'(row_q) + 1'b1 <= band_top);

	// handshake
	assign s1_adv      = valid_s1 && (!emit_s1 || !out_valid_q || mark.ready);
	assign pixel.ready = !valid_s1 || s1_adv;
	assign accept      = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_of_row) begin
				col_q <= '0;
				row_q <= end_of_frame ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// line buffer, both rows in one entry
	vcom_ram #(
		.WIDTH (vcom_pkg::ENTRY_W),
		.DEPTH (vcom_pkg::MAX_COLUMNS)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (wr_entry),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_raw)
	);

	assign rd_entry  = vcom_pkg::line_entry_t'(rd_raw);
	assign cur_entry = fwd_s1 ? fwd_data_s1 : rd_entry;

	always_comb begin
		wr_entry         = '0;
		wr_entry.older_z = cur_entry.newer_z;
		wr_entry.older_v = cur_entry.newer_v;
		wr_entry.newer_z = z_s1;
		wr_entry.newer_v = v_s1;
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_s1        <= pixel.height_z;
			v_s1        <= pixel.point_valid;
			addr_s1     <= col_q;
			emit_s1     <= row_q != '0;
			band_s1     <= in_band;
			rlast_s1    <= end_of_row;
			flast_s1    <= end_of_frame;
			// bypass the write that lands on the column being read
			fwd_s1      <= s1_adv && (addr_s1 == col_q);
			fwd_data_s1 <= wr_entry;
		end
	end

	// second difference and compare
	assign sum = vcom_pkg::CMP_W'(cur_entry.older_z) + vcom_pkg::CMP_W'(z_s1)
		- (vcom_pkg::CMP_W'(cur_entry.newer_z) <<< 1);
	assign thr_x = signed'(vcom_pkg::CMP_W'(threshold_q));
	assign mark_d = band_s1 && cur_entry.older_v && cur_entry.newer_v && v_s1
		&& (sum > thr_x);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (mark.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			mark_q  <= mark_d;
			rlast_q <= rlast_s1;
			flast_q <= flast_s1;
		end
	end

	assign mark.valid         = out_valid_q;
	assign mark.obstacle_mark = mark_q;
	assign mark.row_last      = rlast_q;
	assign mark.frame_last    = flast_q;

	`VCOM_ASSERT_NOW(a_stall_blocks_input, valid_s1 && !s1_adv, !pixel.ready, "ready in stall")
	`VCOM_ASSERT_NOW(a_frame_ends_row, out_valid_q, !flast_q || rlast_q, "frame end off row")
	`VCOM_ASSERT_NEXT(a_frame_wraps, accept && end_of_frame, {row_q, col_q} == '0, "no frame wrap")

endmodule

`default_nettype wire
